// ===== rtl/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int DEF_HEAP_DEPTH = 1024;
    localparam int VALUE_W        = 31;
    localparam int STATUS_W       = 2;
    localparam int TDATA_W        = 32;

    typedef enum logic [0:0] {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CMP,
        S_POP_LAST,
        S_POP_LASTD,
        S_DOWN_R,
        S_DOWN_CMP,
        S_PLACE,
        S_RESULT
    } state_t;

endpackage

// ===== rtl/bmhq_ram.sv =====
// ----------------------------------------------------------------------------
// bmhq_ram
// Heap store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bmhq_ram
    import bmhq_pkg::*;
#(
    parameter int HEAP_DEPTH = DEF_HEAP_DEPTH,
    parameter int AW         = $clog2(HEAP_DEPTH)
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [VALUE_W-1:0] wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output logic [VALUE_W-1:0] rdata
);

    logic [VALUE_W-1:0] mem [HEAP_DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bmhq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for push (sift up) and pop (sift down) over the heap store.
// ----------------------------------------------------------------------------
module bmhq_ctrl
    import bmhq_pkg::*;
#(
    parameter int HEAP_DEPTH = DEF_HEAP_DEPTH,
    parameter int AW         = $clog2(HEAP_DEPTH),
    parameter int CW         = $clog2(HEAP_DEPTH + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mode_t              in_mode,
    input  logic [VALUE_W-1:0] in_value,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output logic [VALUE_W-1:0] mem_wdata,
    output logic               mem_re,
    output logic [AW-1:0]      mem_raddr,
    input  logic [VALUE_W-1:0] mem_rdata
);

    localparam int XW = CW + 1;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [VALUE_W-1:0] child_reg, child_next;
    logic               has_right_reg, has_right_next;
    logic               is_pop_reg, is_pop_next;
    result_t            res_reg, res_next;

    logic               accept;
    logic [AW-1:0]      up_parent;
    logic [AW-1:0]      in_parent;
    logic [XW-1:0]      left_x;
    logic [XW-1:0]      right_x;
    logic [XW-1:0]      count_x;
    logic [VALUE_W-1:0] best_val;
    logic [AW-1:0]      best_pos;
    logic [XW-1:0]      nleft_x;

    assign accept    = in_valid && in_ready;
    assign count_x   = XW'(count_reg);
    assign up_parent = AW'((pos_reg - AW'(1)) >> 1);
    assign in_parent = AW'((count_reg - CW'(1)) >> 1);
    assign left_x    = XW'({pos_reg, 1'b1});
    assign right_x   = left_x + XW'(1);

    // smaller child; right only when strictly smaller than left
    always_comb
    begin
        best_val = child_reg;
        best_pos = left_x[AW-1:0];
        if (has_right_reg && (mem_rdata < child_reg))
        begin
            best_val = mem_rdata;
            best_pos = right_x[AW-1:0];
        end
    end

    assign nleft_x = XW'({best_pos, 1'b1});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        child_reg     <= child_next;
        has_right_reg <= has_right_next;
        is_pop_reg    <= is_pop_next;
        res_reg       <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        child_next     = child_reg;
        has_right_next = has_right_reg;
        is_pop_next    = is_pop_reg;
        res_next       = res_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = val_reg;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    is_pop_next = (in_mode == MODE_POP);
                    if (in_mode == MODE_PUSH)
                    begin
                        if (count_reg == CW'(HEAP_DEPTH))
                        begin
                            res_next.value  = '0;
                            res_next.status = STATUS_FULL;
                            state_next      = S_RESULT;
                        end
                        else if (count_reg == '0)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            mem_wdata  = in_value;
                            count_next = CW'(1);
                        end
                        else
                        begin
                            val_next   = in_value;
                            pos_next   = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                            mem_re     = 1'b1;
                            mem_raddr  = in_parent;
                            state_next = S_UP_CMP;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_next.value  = '0;
                        res_next.status = STATUS_EMPTY;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        mem_re     = 1'b1;
                        mem_raddr  = '0;
                        state_next = S_POP_LAST;
                    end
                end
            end

            S_UP_CMP:
            begin
                if (val_reg < mem_rdata)
                begin
                    // parent moves down into the hole
                    mem_we    = 1'b1;
                    mem_waddr = pos_reg;
                    mem_wdata = mem_rdata;
                    pos_next  = up_parent;
                    if (up_parent == '0)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'((up_parent - AW'(1)) >> 1);
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_POP_LAST:
            begin
                res_next.value  = mem_rdata;
                res_next.status = STATUS_OK;
                mem_re          = 1'b1;
                mem_raddr       = count_reg[AW-1:0];
                state_next      = S_POP_LASTD;
            end

            S_POP_LASTD:
            begin
                val_next = mem_rdata;
                pos_next = '0;
                if (count_reg == '0)
                begin
                    state_next = S_RESULT;
                end
                else if (count_reg > CW'(1))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(1);
                    state_next = S_DOWN_R;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end

            S_DOWN_R:
            begin
                child_next     = mem_rdata;
                has_right_next = (right_x < count_x);
                if (right_x < count_x)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = right_x[AW-1:0];
                end
                state_next = S_DOWN_CMP;
            end

            S_DOWN_CMP:
            begin
                mem_we = 1'b1;
                if (val_reg <= best_val)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    mem_wdata = best_val;
                    pos_next  = best_pos;
                    if (nleft_x < count_x)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = nleft_x[AW-1:0];
                        state_next = S_DOWN_R;
                    end
                    else
                    begin
                        state_next = S_PLACE;
                    end
                end
            end

            S_PLACE:
            begin
                mem_we     = 1'b1;
                state_next = is_pop_reg ? S_RESULT : S_IDLE;
            end

            S_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(HEAP_DEPTH))
        else $error("heap count beyond depth");

    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write hit the same entry");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_mode == MODE_PUSH && count_reg != CW'(HEAP_DEPTH))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push did not grow the heap");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_mode == MODE_POP && count_reg != '0)
        |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("pop did not shrink the heap");

endmodule

// ===== rtl/binary_min_heap_queue.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Min-priority queue kept as a binary heap in a single synchronous memory.
// ----------------------------------------------------------------------------
// usage:
//   input words on s_axis: tuser is the mode (0 push, 1 pop), tdata carries
//   the 31-bit value for a push. output words on m_axis: tdata is the popped
//   value, tuser the status (0 ok, 1 pop on empty heap, 2 push dropped, full).
//   a push that fits returns no word; every pop and every dropped push
//   returns one word.
//   one word is worked on at a time. a push into an empty heap is written
//   to the root; otherwise each level climbed reads the parent and moves it
//   down, then the value is placed. a pop reads the root and the last
//   entry, reads both children of each level compared, writes the moved
//   value in an extra step when it ends with no children left, and hands
//   over the result; full and empty cases go straight to it. the pace is
//   set by the heap memory's single read port: each level reads both children.
//   results sit in an output register, so the next word is accepted while
//   the last result still waits. a result that finds the register full
//   holds the sequencer until the receiver takes the waiting word.
//   reset empties the heap at once; memory contents need no clearing.
// ----------------------------------------------------------------------------
module binary_min_heap_queue
    import bmhq_pkg::*;
#(
    parameter int HEAP_DEPTH = DEF_HEAP_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // [30:0] push_value, [31] zero
    input  logic [0:0]         s_axis_tuser,   // [0] mode
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [30:0] popped_value, [31] zero
    output logic [STATUS_W-1:0] m_axis_tuser   // [1:0] status
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;
    logic               res_valid;
    logic               res_ready;
    result_t            res;

    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    bmhq_ram #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .AW         (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bmhq_ctrl #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (mode_t'(s_axis_tuser[0])),
        .in_value  (s_axis_tdata[VALUE_W-1:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'(out_reg.value);
    assign m_axis_tuser  = out_reg.status;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for binary_min_heap_queue: a directed table of pushes
// and pops, then random traffic that keeps the heap small, fills it to the
// brim with dropped pushes, and drains part of it. Every returned word is
// checked against a heap mirror kept in the bench, or against the word
// written in a directed row, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
    import bmhq_pkg::*;

    localparam int DEPTH      = DEF_HEAP_DEPTH;
    localparam int N_DIRECTED = 22;
    localparam int SMALL_RUN  = 350;
    localparam int TAIL_RUN   = 150;
    localparam int TAIL_WAIT  = 64;

    typedef struct packed {
        mode_t              mode;
        logic [VALUE_W-1:0] value;
        logic               typed;      // expected word written in the row
        logic [VALUE_W-1:0] exp_value;
        status_t            exp_status;
    } step_row_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata  = '0;    // [30:0] push_value, [31] zero
    logic [0:0]          s_axis_tuser  = '0;    // [0] mode
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;          // [30:0] popped_value, [31] zero
    logic [STATUS_W-1:0] m_axis_tuser;          // [1:0] status

    // heap mirror and the words it still owes
    logic [VALUE_W-1:0] heap_mirror [DEPTH];
    int                 mirror_count = 0;
    result_t            pending_results [$];

    int          err_count      = 0;
    int          push_words     = 0;
    int          pop_words      = 0;
    int          minima         = 0;
    int          empty_pops     = 0;
    int          dropped_pushes = 0;
    int          peak_fill      = 0;
    int unsigned burst_left     = 0;
    bit          draining       = 1'b0;
    int unsigned rx_style       = 0;
    int unsigned rx_span        = 0;
    int unsigned rx_tick        = 0;

    step_row_t directed_steps [N_DIRECTED] = '{
        '{MODE_POP,  31'h0,        1'b1, 31'h0,        STATUS_EMPTY},
        '{MODE_POP,  31'h7fffffff, 1'b1, 31'h0,        STATUS_EMPTY},
        '{MODE_PUSH, 31'h7fffffff, 1'b0, 31'h0,        STATUS_OK},
        '{MODE_POP,  31'h0,        1'b1, 31'h7fffffff, STATUS_OK},
        '{MODE_POP,  31'h0,        1'b1, 31'h0,        STATUS_EMPTY},
        '{MODE_PUSH, 31'h7fffffff, 1'b0, 31'h0,        STATUS_OK},
        '{MODE_PUSH, 31'h0,        1'b0, 31'h0,        STATUS_OK},
        '{MODE_PUSH, 31'h2aaaaaaa, 1'b0, 31'h0,        STATUS_OK},
        '{MODE_PUSH, 31'h55555555, 1'b0, 31'h0,        STATUS_OK},
        '{MODE_PUSH, 31'h5,        1'b0, 31'h0,        STATUS_OK},
        '{MODE_PUSH, 31'h5,        1'b0, 31'h0,        STATUS_OK},
        '{MODE_PUSH, 31'h6,        1'b0, 31'h0,        STATUS_OK},
        '{MODE_POP,  31'h0,        1'b1, 31'h0,        STATUS_OK},
        '{MODE_POP,  31'h12345678, 1'b0, 31'h0,        STATUS_OK},
        '{MODE_POP,  31'h7fffffff, 1'b0, 31'h0,        STATUS_OK},
        '{MODE_PUSH, 31'h3,        1'b0, 31'h0,        STATUS_OK},
        '{MODE_POP,  31'h0,        1'b0, 31'h0,        STATUS_OK},
        '{MODE_POP,  31'h0,        1'b0, 31'h0,        STATUS_OK},
        '{MODE_POP,  31'h0,        1'b0, 31'h0,        STATUS_OK},
        '{MODE_POP,  31'h0,        1'b0, 31'h0,        STATUS_OK},
        '{MODE_POP,  31'h0,        1'b1, 31'h7fffffff, STATUS_OK},
        '{MODE_POP,  31'h0,        1'b1, 31'h0,        STATUS_EMPTY}
    };

    binary_min_heap_queue #(
        .HEAP_DEPTH (DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // applies one word to the mirror; returns 1 when the block owes a word back
    function automatic bit heap_apply(input mode_t mode, input logic [VALUE_W-1:0] value,
                                      output result_t res);
        int                 pos;
        int                 parent;
        int                 left;
        int                 pick;
        logic [VALUE_W-1:0] tmp;
        res.value  = '0;
        res.status = STATUS_OK;
        if (mode == MODE_PUSH)
        begin
            if (mirror_count >= DEPTH)
            begin
                res.status = STATUS_FULL;
                dropped_pushes++;
                return 1'b1;
            end
            pos = mirror_count;
            heap_mirror[pos] = value;
            mirror_count++;
            if (mirror_count > peak_fill)
                peak_fill = mirror_count;
            while (pos > 0)
            begin
                parent = (pos - 1) / 2;
                if (heap_mirror[pos] >= heap_mirror[parent])
                    break;
                tmp = heap_mirror[pos];
                heap_mirror[pos] = heap_mirror[parent];
                heap_mirror[parent] = tmp;
                pos = parent;
            end
            return 1'b0;
        end
        if (mirror_count == 0)
        begin
            res.status = STATUS_EMPTY;
            empty_pops++;
            return 1'b1;
        end
        res.value = heap_mirror[0];
        minima++;
        mirror_count--;
        if (mirror_count > 0)
        begin
            heap_mirror[0] = heap_mirror[mirror_count];
            pos = 0;
            while (2 * pos + 1 < mirror_count)
            begin
                left = 2 * pos + 1;
                pick = left;
                // right child only when strictly smaller
                if (left + 1 < mirror_count && heap_mirror[left + 1] < heap_mirror[left])
                    pick = left + 1;
                if (heap_mirror[pos] <= heap_mirror[pick])
                    break;
                tmp = heap_mirror[pos];
                heap_mirror[pos] = heap_mirror[pick];
                heap_mirror[pick] = tmp;
                pos = pick;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return VALUE_W'($urandom_range(0, 15));   // plenty of ties
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic mode_t pick_mode(input int push_pct);
        return ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
    endfunction

    // holds the word until the handshake edge, then books what it owes
    task automatic send_word(input mode_t mode, input logic [VALUE_W-1:0] value,
                             input bit typed, input result_t typed_res);
        result_t res;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, value};
        s_axis_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (mode == MODE_PUSH)
            push_words++;
        else
            pop_words++;
        if (heap_apply(mode, value, res))
            pending_results.push_back(typed ? typed_res : res);
    endtask

    // bursts of random length with random gaps between them
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= $urandom;
                s_axis_tuser  <= 1'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // receiver switches between always ready, coin flip, mostly stalled, periodic
    always @(posedge clk)
    begin
        if (rx_span == 0)
        begin
            rx_style = $urandom_range(0, 3);
            rx_span  = $urandom_range(40, 400);
        end
        rx_span--;
        rx_tick++;
        if (draining)
            m_axis_tready <= 1'b1;
        else
        begin
            case (rx_style)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
                default: m_axis_tready <= ((rx_tick % 5) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin : check_words
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected word: expected none, got value %h status %0d",
                         $time, m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== TDATA_W'(want.value))
                begin
                    err_count++;
                    $display("%0t: popped_value mismatch: expected %h, got %h",
                             $time, TDATA_W'(want.value), m_axis_tdata);
                end
                if (m_axis_tuser !== want.status)
                begin
                    err_count++;
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, m_axis_tuser);
                end
            end
        end
    end

    initial
    begin
        result_t typed_res;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            typed_res.value  = directed_steps[i].exp_value;
            typed_res.status = directed_steps[i].exp_status;
            send_word(directed_steps[i].mode, directed_steps[i].value,
                      directed_steps[i].typed, typed_res);
            pace_sender();
        end

        // small heap, frequent empty pops
        typed_res = '0;
        repeat (SMALL_RUN)
        begin
            send_word(pick_mode(mirror_count < 6 ? 60 : 40), pick_value(), 1'b0, typed_res);
            pace_sender();
        end

        // fill to the top and keep knocking on it
        while (!(mirror_count == DEPTH && dropped_pushes >= 8))
        begin
            send_word(pick_mode(94), pick_value(), 1'b0, typed_res);
            pace_sender();
        end

        repeat (TAIL_RUN)
        begin
            send_word(pick_mode(25), pick_value(), 1'b0, typed_res);
            pace_sender();
        end

        s_axis_tvalid <= 1'b0;
        draining = 1'b1;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        $display("sent %0d words: %0d pushes, %0d pops; heap peaked at %0d of %0d entries",
                 push_words + pop_words, push_words, pop_words, peak_fill, DEPTH);
        $display("returned %0d minima, %0d empty pops, %0d dropped pushes",
                 minima, empty_pops, dropped_pushes);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("timeout with %0d words still owed", pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bmhq_pkg.sv
rtl/bmhq_ram.sv
rtl/bmhq_ctrl.sv
rtl/binary_min_heap_queue.sv
tb/tb_top.sv
